/* sv/top_k_score_selector_top_assert.svh */
// Assertion macros shared by the checker.
`ifndef TOP_K_SCORE_SELECTOR_TOP_ASSERT_SVH
`define TOP_K_SCORE_SELECTOR_TOP_ASSERT_SVH

// Same-cycle implication, gated by reset.
`define TKSEL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("top-k selector check failed");

// Next-cycle implication, gated by reset.
`define TKSEL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("top-k selector check failed");

`endif

/* sv/tksel_pkg.sv */
`timescale 1ns / 1ps

package tksel_pkg;

    localparam int TOP_COUNT_DEF = 16;
    localparam int ID_W          = 24;
    localparam int SCORE_W       = 32;

    // Request modes
    localparam logic MODE_OFFER = 1'b0;
    localparam logic MODE_DRAIN = 1'b1;

    // One held entry of the sorted chain
    typedef struct packed {
        logic               valid;
        logic [SCORE_W-1:0] score;
        logic [ID_W-1:0]    id;
    } t_entry;

    // Broadcast control to every cell
    typedef struct packed {
        logic ins;   // insert the offered entry
        logic shl;   // shift toward the head (drain)
    } t_cell_ctrl;

endpackage

/* sv/tksel_cell.sv */
`timescale 1ns / 1ps

module tksel_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tksel_pkg::t_cell_ctrl         i_ctrl,
    input  logic [tksel_pkg::SCORE_W-1:0] i_new_score,
    input  logic [tksel_pkg::ID_W-1:0]    i_new_id,
    input  tksel_pkg::t_entry             i_prev,
    input  logic                          i_prev_gt,
    input  tksel_pkg::t_entry             i_next,
    output tksel_pkg::t_entry             o_entry,
    output logic                          o_gt
);

    tksel_pkg::t_entry r_entry;
    tksel_pkg::t_entry n_entry;

    // New score goes ahead of this cell (strictly greater, or cell empty)
    assign o_gt = !r_entry.valid || (i_new_score > r_entry.score);

    always_comb begin
        n_entry = r_entry;
        if (i_ctrl.ins) begin
            if (o_gt && !i_prev_gt) begin
                n_entry.valid = 1'b1;
                n_entry.score = i_new_score;
                n_entry.id    = i_new_id;
            end else if (o_gt) begin
                n_entry = i_prev;
            end
        end else if (i_ctrl.shl) begin
            n_entry = i_next;
        end
    end

    // Only the valid bit is reset; payload is don't-care while invalid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry.valid <= 1'b0;
        end else begin
            r_entry.valid <= n_entry.valid;
        end
        r_entry.score <= n_entry.score;
        r_entry.id    <= n_entry.id;
    end

    assign o_entry = r_entry;

endmodule

/* sv/top_k_score_selector_top.sv */
`timescale 1ns / 1ps
// Offer request: accepted in any cycle with no drain running, stored at the accepting edge.
// Drain request: sets the drain flag, then results leave the output register, one per cycle while
//   the output is not stalled; requests are stalled for the length of the drain
//   (a drain of an empty store ends in the next cycle and gives no result).
// Cell chain compares all held entries in parallel, so offers sustain 1 per cycle while no drain runs.
// Synchronous active-low reset empties the chain and drops the output valid.
module top_k_score_selector_top #(
    parameter int TOP_COUNT = tksel_pkg::TOP_COUNT_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_mode,
    input  logic [tksel_pkg::ID_W-1:0]    i_doc_id,
    input  logic [tksel_pkg::SCORE_W-1:0] i_score,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [tksel_pkg::ID_W-1:0]    o_ranked_doc,
    output logic [tksel_pkg::SCORE_W-1:0] o_ranked_score,
    output logic                          o_last
);

    tksel_pkg::t_entry     w_ent  [TOP_COUNT+1];
    tksel_pkg::t_entry     w_prev [TOP_COUNT];
    logic                  w_gt   [TOP_COUNT+1];
    tksel_pkg::t_cell_ctrl w_ctrl;
    logic                  w_accept;
    logic                  w_emit;

    logic                          r_draining;
    logic                          r_out_valid;
    logic [tksel_pkg::ID_W-1:0]    r_out_doc;
    logic [tksel_pkg::SCORE_W-1:0] r_out_score;
    logic                          r_out_last;

    assign w_accept = i_in_valid && !r_draining;
    assign w_emit   = r_draining && w_ent[0].valid && (!r_out_valid || !i_out_stall);

    assign w_ctrl.ins = w_accept && (i_mode == tksel_pkg::MODE_OFFER);
    assign w_ctrl.shl = w_emit;

    // Chain ends: nothing ahead of the head, an empty slot past the tail
    assign w_gt[0]          = 1'b0;
    assign w_ent[TOP_COUNT] = '0;

    // Sorted cell chain, head holds the highest score
    for (genvar gi = 0; gi < TOP_COUNT; gi++) begin : g_cell
        if (gi == 0) begin : g_head
            assign w_prev[gi] = '0;
        end else begin : g_body
            assign w_prev[gi] = w_ent[gi-1];
        end

        tksel_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctrl      (w_ctrl),
            .i_new_score (i_score),
            .i_new_id    (i_doc_id),
            .i_prev      (w_prev[gi]),
            .i_prev_gt   (w_gt[gi]),
            .i_next      (w_ent[gi+1]),
            .o_entry     (w_ent[gi]),
            .o_gt        (w_gt[gi+1])
        );
    end

    // Drain control and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_draining  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept && (i_mode == tksel_pkg::MODE_DRAIN)) begin
                r_draining <= 1'b1;
            end else if (r_draining && (!w_ent[0].valid || (w_emit && !w_ent[1].valid))) begin
                r_draining <= 1'b0;
            end

            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end

        if (w_emit) begin
            r_out_doc   <= w_ent[0].id;
            r_out_score <= w_ent[0].score;
            r_out_last  <= !w_ent[1].valid;
        end
    end

    assign o_in_stall     = r_draining;
    assign o_out_valid    = r_out_valid;
    assign o_ranked_doc   = r_out_doc;
    assign o_ranked_score = r_out_score;
    assign o_last         = r_out_last;

endmodule

/* sv/tksel_checker.sv */
`timescale 1ns / 1ps
`include "top_k_score_selector_top_assert.svh"

module tksel_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_stall,
    input logic                          i_mode,
    input logic [tksel_pkg::ID_W-1:0]    i_doc_id,
    input logic [tksel_pkg::SCORE_W-1:0] i_score,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic [tksel_pkg::ID_W-1:0]    o_ranked_doc,
    input logic [tksel_pkg::SCORE_W-1:0] o_ranked_score,
    input logic                          o_last
);

    // Stalled result holds
    `TKSEL_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_ranked_doc) && $stable(o_ranked_score) && $stable(o_last))

    // Drain results follow back to back in non-increasing score
    `TKSEL_ASSERT_NEXT(a_descending, i_clk, i_rst_n, o_out_valid && !i_out_stall && !o_last, o_out_valid && (o_ranked_score <= $past(o_ranked_score)))

    // Requests are held off while a drain is still emitting
    `TKSEL_ASSERT_NOW(a_stall_mid_drain, i_clk, i_rst_n, o_out_valid && !o_last, o_in_stall)

    // An accepted drain request stalls the next request
    `TKSEL_ASSERT_NEXT(a_drain_stalls, i_clk, i_rst_n, i_in_valid && !o_in_stall && (i_mode == tksel_pkg::MODE_DRAIN), o_in_stall)

endmodule

bind top_k_score_selector_top tksel_checker u_tksel_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .i_mode         (i_mode),
    .i_doc_id       (i_doc_id),
    .i_score        (i_score),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_ranked_doc   (o_ranked_doc),
    .o_ranked_score (o_ranked_score),
    .o_last         (o_last)
);

/* tb/sv/tb_top_k_score_selector_top.sv */
`timescale 1ns / 1ps

module tb_top_k_score_selector_top;

    localparam int KEEP      = tksel_pkg::TOP_COUNT_DEF;
    localparam int ID_W      = tksel_pkg::ID_W;
    localparam int SCORE_W   = tksel_pkg::SCORE_W;
    localparam int LIMIT     = 200000;
    localparam int RAND_REQS = 340;

    // One ranked entry as it leaves the block
    typedef struct packed {
        logic [ID_W-1:0]    doc;
        logic [SCORE_W-1:0] score;
        logic               last;
    } t_ranked;

    // Directed stimulus row; fixed rows carry a typed single-entry drain result
    typedef struct packed {
        logic               mode;
        logic [ID_W-1:0]    doc;
        logic [SCORE_W-1:0] score;
        int                 reps;
        bit                 fixed;
        logic [ID_W-1:0]    exp_doc;
        logic [SCORE_W-1:0] exp_score;
    } t_stim_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic               i_mode = tksel_pkg::MODE_OFFER;
    logic [ID_W-1:0]    i_doc_id = '0;
    logic [SCORE_W-1:0] i_score = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic [ID_W-1:0]    o_ranked_doc;
    logic [SCORE_W-1:0] o_ranked_score;
    logic               o_last;

    // Shadow of the sorted store
    logic [SCORE_W-1:0] held_score [KEEP];
    logic [ID_W-1:0]    held_doc [KEEP];
    int                 held_n = 0;

    t_ranked   ranked_expect [$];
    t_ranked   want;
    t_stim_row dir_rows [15];

    int err_count = 0;
    int cycle_count = 0;
    int hold_left = 0;
    bit calm = 1'b0;

    top_k_score_selector_top #(
        .TOP_COUNT(KEEP)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_mode         (i_mode),
        .i_doc_id       (i_doc_id),
        .i_score        (i_score),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_ranked_doc   (o_ranked_doc),
        .o_ranked_score (o_ranked_score),
        .o_last         (o_last)
    );

    always #5 i_clk = ~i_clk;

    // Run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT) begin
            $display("top_k_score_selector_top: mismatch");
            $finish;
        end
    end

    // Receiver hold-off countdown
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Output stall: long hold-off, else random unless in the calm stretch
    always @(posedge i_clk) begin
        i_out_stall <= (hold_left > 0) || (!calm && $urandom_range(0, 99) < 36);
    end

    task automatic report_miss(input string what, input logic [31:0] got,
                               input logic [31:0] exp_val);
        $display("%0t ns: %s: got %h, expected %h", $time, what, got, exp_val);
        err_count++;
    endtask

    // Compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (ranked_expect.size() == 0) begin
                report_miss("unexpected ranked entry", {8'h0, o_ranked_doc}, '0);
            end else begin
                want = ranked_expect.pop_front();
                if (o_ranked_doc !== want.doc)
                    report_miss("ranked_doc", {8'h0, o_ranked_doc}, {8'h0, want.doc});
                if (o_ranked_score !== want.score)
                    report_miss("ranked_score", o_ranked_score, want.score);
                if (o_last !== want.last)
                    report_miss("last", {31'h0, o_last}, {31'h0, want.last});
            end
        end
    end

    // Append one expected entry at the back of the queue
    function automatic void expect_entry(input logic [ID_W-1:0] doc,
                                         input logic [SCORE_W-1:0] score,
                                         input logic last);
        t_ranked ent;
        ent.doc   = doc;
        ent.score = score;
        ent.last  = last;
        ranked_expect = {ranked_expect, ent};
    endfunction

    // Insert after every entry scoring >= the new one (ties keep arrival order)
    function automatic void rank_insert(input logic [ID_W-1:0] doc,
                                        input logic [SCORE_W-1:0] score);
        int pos;
        pos = 0;
        while (pos < held_n && held_score[pos] >= score) pos++;
        for (int i = held_n; i > pos; i--) begin
            held_score[i] = held_score[i-1];
            held_doc[i]   = held_doc[i-1];
        end
        held_score[pos] = score;
        held_doc[pos]   = doc;
        held_n++;
    endfunction

    // Offer keeps the entry if it ranks in the store; drain ranks everything out and empties the store
    function automatic void predict_request(input logic mode, input logic [ID_W-1:0] doc,
                                            input logic [SCORE_W-1:0] score);
        if (mode == tksel_pkg::MODE_OFFER) begin
            if (held_n < KEEP) begin
                rank_insert(doc, score);
            end else if (score > held_score[KEEP-1]) begin
                // full store: the newest of the minimum scores drops out
                held_n = KEEP - 1;
                rank_insert(doc, score);
            end
        end else begin
            for (int i = 0; i < held_n; i++)
                expect_entry(held_doc[i], held_score[i], i == held_n - 1);
            held_n = 0;
        end
    endfunction

    // Present one request and wait for its acceptance
    task automatic issue_request(input logic mode, input logic [ID_W-1:0] doc,
                                 input logic [SCORE_W-1:0] score);
        int gap;
        if (!calm && $urandom_range(0, 99) < 36) begin
            gap = $urandom_range(1, 3);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_mode     <= mode;
        i_doc_id   <= doc;
        i_score    <= score;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic send_checked(input logic mode, input logic [ID_W-1:0] doc,
                                input logic [SCORE_W-1:0] score);
        issue_request(mode, doc, score);
        predict_request(mode, doc, score);
    endtask

    // Sender pauses until every expected entry has come out
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (ranked_expect.size() != 0);
    endtask

    initial begin
        int sent;
        int kind;
        int n;
        int pool;
        logic [SCORE_W-1:0] sc;

        dir_rows = '{
            '{tksel_pkg::MODE_DRAIN, 24'h000000, 32'h00000000,  1, 1'b0, '0, '0},
            '{tksel_pkg::MODE_OFFER, 24'hFFFFFF, 32'hFFFFFFFF,  1, 1'b0, '0, '0},
            '{tksel_pkg::MODE_DRAIN, 24'h000000, 32'h00000000,  1, 1'b1,
              24'hFFFFFF, 32'hFFFFFFFF},
            '{tksel_pkg::MODE_OFFER, 24'h000000, 32'h00000000,  1, 1'b0, '0, '0},
            '{tksel_pkg::MODE_DRAIN, 24'hFFFFFF, 32'hFFFFFFFF,  1, 1'b1,
              24'h000000, 32'h00000000},
            // equal scores come out in arrival order
            '{tksel_pkg::MODE_OFFER, 24'h000001, 32'h00010000,  1, 1'b0, '0, '0},
            '{tksel_pkg::MODE_OFFER, 24'h000002, 32'h00010000,  1, 1'b0, '0, '0},
            '{tksel_pkg::MODE_OFFER, 24'h000003, 32'h00020000,  1, 1'b0, '0, '0},
            '{tksel_pkg::MODE_DRAIN, 24'h000000, 32'h00000000,  1, 1'b0, '0, '0},
            // fill with one score, then tie (kept out), greater (evicts newest), lower
            '{tksel_pkg::MODE_OFFER, 24'h000100, 32'h00008000, 16, 1'b0, '0, '0},
            '{tksel_pkg::MODE_OFFER, 24'h000200, 32'h00008000,  1, 1'b0, '0, '0},
            '{tksel_pkg::MODE_OFFER, 24'h000300, 32'h00008001,  1, 1'b0, '0, '0},
            '{tksel_pkg::MODE_OFFER, 24'h000400, 32'h00007FFF,  1, 1'b0, '0, '0},
            '{tksel_pkg::MODE_DRAIN, 24'h000000, 32'h00000000,  1, 1'b0, '0, '0},
            // drain of an empty store, payload ignored
            '{tksel_pkg::MODE_DRAIN, 24'hABCDEF, 32'h12345678,  1, 1'b0, '0, '0}
        };

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table
        foreach (dir_rows[r]) begin
            for (int k = 0; k < dir_rows[r].reps; k++) begin
                issue_request(dir_rows[r].mode, dir_rows[r].doc + ID_W'(k),
                              dir_rows[r].score);
                if (dir_rows[r].fixed) begin
                    held_n = 0;
                    expect_entry(dir_rows[r].exp_doc, dir_rows[r].exp_score, 1'b1);
                end else begin
                    predict_request(dir_rows[r].mode, dir_rows[r].doc + ID_W'(k),
                                    dir_rows[r].score);
                end
            end
        end

        // Backpressure: receiver holds off while requests keep coming
        wait_drained();
        hold_left <= 300;
        for (int k = 0; k < KEEP; k++)
            send_checked(tksel_pkg::MODE_OFFER, ID_W'($urandom()), $urandom());
        send_checked(tksel_pkg::MODE_DRAIN, '0, '0);
        for (int k = 0; k < 12; k++)
            send_checked(tksel_pkg::MODE_OFFER, ID_W'($urandom()), $urandom());
        send_checked(tksel_pkg::MODE_DRAIN, '0, '0);
        wait_drained();

        // Random part: mostly offer bursts closed by a drain, some noise
        sent = 0;
        while (sent < RAND_REQS) begin
            calm <= (sent >= 150 && sent < 250);
            kind = $urandom_range(0, 9);
            if (kind < 8) begin
                n = ($urandom_range(0, 3) == 0) ? $urandom_range(17, 40)
                                                : $urandom_range(1, 16);
                pool = $urandom_range(0, 2);
                for (int k = 0; k < n; k++) begin
                    case (pool)
                        0: sc = $urandom();
                        1: sc = {16'($urandom_range(0, 3)), 16'h8000};
                        default: sc = {16'($urandom()), 16'h0000};
                    endcase
                    send_checked(tksel_pkg::MODE_OFFER, ID_W'($urandom()), sc);
                end
                send_checked(tksel_pkg::MODE_DRAIN, ID_W'($urandom()), $urandom());
                sent += n + 1;
                if ($urandom_range(0, 5) == 0) wait_drained();
            end else begin
                n = $urandom_range(1, 6);
                for (int k = 0; k < n; k++)
                    send_checked(1'($urandom()), ID_W'($urandom()), $urandom());
                sent += n;
            end
        end
        calm <= 1'b0;

        // Let everything come out, then keep watching for stray results
        wait_drained();
        repeat (20) @(posedge i_clk);
        if (err_count == 0) begin
            $display("top_k_score_selector_top: match");
        end else begin
            $display("top_k_score_selector_top: mismatch");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+sv
sv/tksel_pkg.sv
sv/tksel_cell.sv
sv/top_k_score_selector_top.sv
sv/tksel_checker.sv
tb/sv/tb_top_k_score_selector_top.sv
